>>> hdl/ssl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssl_pkg
// Shared types, character classes and keyword spelling for the source lexer.
// ----------------------------------------------------------------------------
package ssl_pkg;

  typedef enum logic [2:0] {
    KIND_KEYWORD = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_NUMBER  = 3'd2,
    KIND_OPER    = 3'd3,
    KIND_PUNCT   = 3'd4,
    KIND_ERROR   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2
  } mode_t;

  typedef enum logic {
    BK_IDLE  = 1'b0,
    BK_DRAIN = 1'b1
  } back_state_t;

  // Wide enough for a word length of up to 127 characters.
  localparam int CMD_LEN_W = 7;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // One entry of the queue between the front and the back.
  typedef struct packed {
    logic                 is_word;
    kind_t                kind;
    logic [7:0]           ch;
    logic [CMD_LEN_W-1:0] len;
    logic                 bank;
  } cmd_t;

  // The back hands a buffer bank back to the front when its word is drained.
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return c == 8'h28 || c == 8'h29 || c == 8'h5B || c == 8'h5D ||
           c == 8'h7B || c == 8'h7D || c == 8'h3B;
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    return c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F ||
           c == 8'h25 || c == 8'h3D;
  endfunction

  function automatic logic [7:0] int_char(input logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd0:    r = 8'h69;
      3'd1:    r = 8'h6E;
      3'd2:    r = 8'h74;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] void_char(input logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd0:    r = 8'h76;
      3'd1:    r = 8'h6F;
      3'd2:    r = 8'h69;
      3'd3:    r = 8'h64;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] public_char(input logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd0:    r = 8'h70;
      3'd1:    r = 8'h75;
      3'd2:    r = 8'h62;
      3'd3:    r = 8'h6C;
      3'd4:    r = 8'h69;
      3'd5:    r = 8'h63;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/ssl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ssl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hdl/ssl_cmdq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssl_cmdq
// Four-entry queue of token commands between the front and the back.
// ----------------------------------------------------------------------------
module ssl_cmdq
  import ssl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty
);

  cmd_t       entries [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  logic do_push;
  logic do_pop;

  assign full    = count == 3'd4;
  assign empty   = count == 3'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 3'd1;
        2'b01:   count <= count - 3'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/ssl_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssl_front
// Accepts source bytes, classifies them, buffers words into the RAM and
// queues token commands for the back.
// ----------------------------------------------------------------------------
module ssl_front
  import ssl_pkg::*;
#(
  parameter int MAX_WORD_LEN = 32,
  parameter int AW           = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    char_in,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          q_full,
  output logic               push,
  output cmd_t               push_cmd,
  input  wire rel_t          rel,
  output logic               we,
  output logic [AW-1:0]      waddr,
  output logic [7:0]         wdata
);

  localparam int LENW = $clog2(MAX_WORD_LEN + 1);
  localparam int IDXW = AW - 1;

  mode_t           mode;
  mode_t           mode_next;
  logic [LENW-1:0] word_len;
  logic [LENW-1:0] word_len_next;
  logic            halted;
  logic            halted_next;
  logic            bank;
  logic            bank_next;
  logic [1:0]      busy;
  logic [1:0]      busy_next;
  logic            m_int;
  logic            m_int_next;
  logic            m_void;
  logic            m_void_next;
  logic            m_public;
  logic            m_public_next;

  logic            acc;
  logic            in_word;
  logic            c_letter;
  logic            c_digit;
  logic            c_space;
  logic            word_ok;
  logic            keyword;
  logic [LENW-1:0] pos;
  logic            set_busy;

  assign c_letter = is_letter(char_in);
  assign c_digit  = is_digit(char_in);
  assign c_space  = char_in == CH_SPACE;
  assign in_word  = mode == MODE_IDENT || mode == MODE_NUMBER;
  assign word_ok  = (mode == MODE_IDENT) ? (c_letter || c_digit || char_in == CH_UNDER)
                                         : c_digit;
  assign pos      = in_word ? word_len : '0;
  assign keyword  = (word_len == LENW'(3) && m_int) ||
                    (word_len == LENW'(4) && m_void) ||
                    (word_len == LENW'(6) && m_public);

  // A new word may only start in a bank the back has finished draining.
  assign in_stall = !halted && (q_full || (!in_word && busy[bank]));
  assign acc      = in_valid && !in_stall;

  always_comb begin
    mode_next = mode;
    if (acc && !halted) begin
      unique case (mode)
        MODE_IDENT, MODE_NUMBER: begin
          if (c_space) begin
            mode_next = MODE_START;
          end
        end
        default: begin
          if (c_letter) begin
            mode_next = MODE_IDENT;
          end else if (c_digit) begin
            mode_next = MODE_NUMBER;
          end
        end
      endcase
    end
  end

  always_comb begin
    push          = 1'b0;
    push_cmd      = '0;
    we            = 1'b0;
    waddr         = {bank, pos[IDXW-1:0]};
    wdata         = char_in;
    word_len_next = word_len;
    halted_next   = halted;
    bank_next     = bank;
    set_busy      = 1'b0;
    m_int_next    = m_int;
    m_void_next   = m_void;
    m_public_next = m_public;
    if (acc && !halted) begin
      if (in_word && c_space) begin
        push             = 1'b1;
        push_cmd.is_word = 1'b1;
        push_cmd.kind    = (mode == MODE_NUMBER) ? KIND_NUMBER
                           : (keyword ? KIND_KEYWORD : KIND_IDENT);
        push_cmd.len     = CMD_LEN_W'(word_len);
        push_cmd.bank    = bank;
        word_len_next    = '0;
        bank_next        = ~bank;
        set_busy         = 1'b1;
      end else if ((in_word && word_ok && word_len < LENW'(MAX_WORD_LEN)) ||
                   (!in_word && (c_letter || c_digit))) begin
        we            = 1'b1;
        word_len_next = LENW'(pos + 1'b1);
        m_int_next    = (pos == '0 || m_int) && pos < LENW'(3) &&
                        char_in == int_char(pos[2:0]);
        m_void_next   = (pos == '0 || m_void) && pos < LENW'(4) &&
                        char_in == void_char(pos[2:0]);
        m_public_next = (pos == '0 || m_public) && pos < LENW'(6) &&
                        char_in == public_char(pos[2:0]);
      end else if (in_word) begin
        // Bad character or a word that outgrows the buffer.
        push          = 1'b1;
        push_cmd.kind = KIND_ERROR;
        push_cmd.ch   = 8'h00;
        halted_next   = 1'b1;
      end else if (is_punct(char_in)) begin
        push          = 1'b1;
        push_cmd.kind = KIND_PUNCT;
        push_cmd.ch   = char_in;
      end else if (is_oper(char_in)) begin
        push          = 1'b1;
        push_cmd.kind = KIND_OPER;
        push_cmd.ch   = char_in;
      end
    end
  end

  always_comb begin
    busy_next = busy;
    if (set_busy) begin
      busy_next[bank] = 1'b1;
    end
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_START;
      word_len <= '0;
      halted   <= 1'b0;
      bank     <= 1'b0;
      busy     <= '0;
    end else begin
      mode     <= mode_next;
      word_len <= word_len_next;
      halted   <= halted_next;
      bank     <= bank_next;
      busy     <= busy_next;
    end
  end

  always_ff @(posedge clk) begin
    m_int    <= m_int_next;
    m_void   <= m_void_next;
    m_public <= m_public_next;
  end

endmodule
`default_nettype wire

>>> hdl/ssl_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssl_back
// Executes queued token commands: single-character tokens go straight to the
// output register, words are read back from the RAM one character at a time.
// ----------------------------------------------------------------------------
module ssl_back
  import ssl_pkg::*;
#(
  parameter int MAX_WORD_LEN = 32,
  parameter int AW           = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cmd_t          head,
  input  wire logic          q_empty,
  output logic               pop,
  output rel_t               rel,
  output logic               re,
  output logic [AW-1:0]      raddr,
  input  wire logic [7:0]    rdata,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [2:0]         token_kind,
  output logic [7:0]         token_char,
  output logic               last_char
);

  localparam int LENW = $clog2(MAX_WORD_LEN + 1);
  localparam int IDXW = AW - 1;

  back_state_t     state;
  back_state_t     state_next;
  logic [LENW-1:0] cnt;
  logic [LENW-1:0] wlen;
  logic            wbank;
  kind_t           wkind;
  logic            rd_pend;
  logic            rd_last;

  logic            out_free;
  logic            load_single;

  assign out_free = !out_valid || !out_stall;
  assign raddr    = {wbank, cnt[IDXW-1:0]};

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty && head.is_word) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (rd_pend && rd_last) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop         = 1'b0;
    load_single = 1'b0;
    re          = 1'b0;
    rel.valid   = 1'b0;
    rel.bank    = wbank;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty && (head.is_word || out_free)) begin
          pop         = 1'b1;
          load_single = !head.is_word;
        end
      end
      BK_DRAIN: begin
        // A read is only issued when the output register will be empty by the
        // time the registered read data comes back.
        re        = !rd_pend && out_free;
        rel.valid = rd_pend && rd_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (load_single || rd_pend) begin
        out_valid <= 1'b1;
      end
      if (re) begin
        rd_pend <= 1'b1;
      end else if (rd_pend) begin
        rd_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.is_word) begin
      cnt   <= '0;
      wlen  <= LENW'(head.len);
      wbank <= head.bank;
      wkind <= head.kind;
    end
    if (re) begin
      rd_last <= cnt == LENW'(wlen - 1'b1);
      cnt     <= LENW'(cnt + 1'b1);
    end
    if (load_single) begin
      token_kind <= head.kind;
      token_char <= head.ch;
      last_char  <= 1'b1;
    end else if (rd_pend) begin
      token_kind <= wkind;
      token_char <= rdata;
      last_char  <= rd_last;
    end
  end

endmodule
`default_nettype wire

>>> hdl/simple_source_lexer_core.sv
`default_nettype none
// A one-character token or an error goes through the command queue and the
// output register. A word is queued at its ending space, then its characters
// are read one at a time via the RAM's registered read port into the output
// register, each read only once the previous one has returned. Bytes are
// taken one per cycle while the queue has room and the next word's buffer bank is free.
// Reset clears all control state; the word buffer contents are not cleared.
// ----------------------------------------------------------------------------
// simple_source_lexer_core
// Byte-stream lexer: front classifies and buffers, back emits token beats.
// ----------------------------------------------------------------------------
module simple_source_lexer_core
  import ssl_pkg::*;
#(
  parameter int MAX_WORD_LEN = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] char_in,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic [2:0]      token_kind,
  output logic [7:0]      token_char,
  output logic            last_char,
  output logic            out_valid,
  input  wire logic       out_stall
);

  localparam int IDXW      = $clog2(MAX_WORD_LEN);
  localparam int AW        = IDXW + 1;
  localparam int RAM_DEPTH = 2 * (1 << IDXW);

  logic          q_full;
  logic          q_empty;
  logic          push;
  logic          pop;
  cmd_t          push_cmd;
  cmd_t          head;
  rel_t          rel;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;

  ssl_front #(
    .MAX_WORD_LEN(MAX_WORD_LEN),
    .AW          (AW)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_in),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .q_full  (q_full),
    .push    (push),
    .push_cmd(push_cmd),
    .rel     (rel),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata)
  );

  ssl_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty)
  );

  ssl_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  ssl_back #(
    .MAX_WORD_LEN(MAX_WORD_LEN),
    .AW          (AW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .rel       (rel),
    .re        (re),
    .raddr     (raddr),
    .rdata     (rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .token_kind(token_kind),
    .token_char(token_char),
    .last_char (last_char)
  );

endmodule
`default_nettype wire
